// ===== rtl/core/stb_pkg.sv =====
package stb_pkg;

	localparam int TIMERS  = 16;
	localparam int IDX_W   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int ID_W    = 5;
	localparam int MASK_W  = 16;
	localparam int TICK_W  = 10;
	localparam int COUNT_W = 32;
	localparam int ACT_W   = 3;

	localparam logic [TICK_W-1:0] DEFAULT_TICK = TICK_W'(10);
	localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(TIMERS - 1);

	localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SET     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_KILL    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RESTART = 3'd3;
	localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd4;

	typedef struct packed {
		logic load;
		logic step;
		logic push;
	} stb_cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} stb_status_t;

endpackage

// ===== rtl/core/stb_ifs.sv =====
interface stb_req_if import stb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [ID_W-1:0]    timer_id;
	logic [COUNT_W-1:0] period_ms;

	modport source (output valid, action, timer_id, period_ms, input ready);
	modport sink (input valid, action, timer_id, period_ms, output ready);
endinterface

interface stb_rsp_if import stb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   granted_id;
	logic              success;
	logic [MASK_W-1:0] expired_mask;

	modport source (output valid, granted_id, success, expired_mask, input ready);
	modport sink (input valid, granted_id, success, expired_mask, output ready);
endinterface

interface stb_cfg_if import stb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] tick_ms;

	modport source (output valid, tick_ms, input ready);
	modport sink (input valid, tick_ms, output ready);
endinterface

// ===== rtl/core/stb_ctrl.sv =====
module stb_ctrl import stb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  stb_status_t st,
	output stb_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_PUSH = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (st.done) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				// Wait here until the output register can take the word.
				if (st.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> st.out_free)
		else $error("result pushed into a full output register");

	a_load_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_RUN))
		else $error("accepted word did not start processing");

	a_done_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && st.done) |=> (state_q == S_PUSH))
		else $error("finished operation did not move to push");

endmodule

// ===== rtl/core/stb_dp.sv =====
module stb_dp import stb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  stb_cmd_t           cmd,
	output stb_status_t        st,
	input  logic [ACT_W-1:0]   req_action,
	input  logic [ID_W-1:0]    req_timer_id,
	input  logic [COUNT_W-1:0] req_period_ms,
	input  logic               cfg_valid,
	input  logic [TICK_W-1:0]  cfg_tick_ms,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [ID_W-1:0]    rsp_granted_id,
	output logic               rsp_success,
	output logic [MASK_W-1:0]  rsp_expired_mask
);

	logic [TICK_W-1:0]  tick_q;
	logic [ACT_W-1:0]   act_q;
	logic [ID_W-1:0]    id_q;
	logic [COUNT_W-1:0] per_q;
	logic [IDX_W-1:0]   idx_q;
	logic [ID_W-1:0]    granted_q;
	logic               ok_q;
	logic [MASK_W-1:0]  mask_q;

	logic [TIMERS-1:0]  enabled_q;
	logic [TIMERS-1:0]  expired_q;
	logic [COUNT_W-1:0] elapsed_q [TIMERS];
	logic [COUNT_W-1:0] period_q [TIMERS];

	logic               out_valid_q;
	logic [ID_W-1:0]    out_granted_q;
	logic               out_ok_q;
	logic [MASK_W-1:0]  out_mask_q;

	logic               id_ok;
	logic               alloc_mode;
	logic               sweep;
	logic [ID_W-1:0]    id_m1;
	logic [IDX_W-1:0]   sel;
	logic               cur_en;
	logic               cur_exp;
	logic [COUNT_W-1:0] cur_el;
	logic [COUNT_W-1:0] cur_per;
	logic [TICK_W-1:0]  step_ms;
	logic [COUNT_W:0]   sum;
	logic [COUNT_W-1:0] sat;
	logic               hit;

	logic               wr_en, en_val;
	logic               wr_exp, exp_val;
	logic               wr_el;
	logic [COUNT_W-1:0] el_val;
	logic               wr_per;
	logic [COUNT_W-1:0] per_val;
	logic               mask_set;
	logic               grant_set;
	logic               ok_set;
	logic [ID_W-1:0]    grant_val;
	logic [MASK_W-1:0]  mask_bit;

	assign id_ok      = (id_q != '0) && (id_q <= ID_W'(TIMERS));
	assign alloc_mode = (act_q == ACT_SET) && (id_q == '0) && (per_q != '0);
	assign sweep      = (act_q == ACT_TICK) || alloc_mode;
	assign id_m1      = id_q - ID_W'(1);
	assign sel        = sweep ? idx_q : id_m1[IDX_W-1:0];

	assign cur_en  = enabled_q[sel];
	assign cur_exp = expired_q[sel];
	assign cur_el  = elapsed_q[sel];
	assign cur_per = period_q[sel];

	// A zero tick size counts as the default.
	assign step_ms = (tick_q == '0) ? DEFAULT_TICK : tick_q;
	assign sum     = {1'b0, cur_el} + (COUNT_W+1)'(step_ms);
	assign sat     = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
	assign hit     = (sat >= cur_per);

	assign grant_val = alloc_mode ? (ID_W'(idx_q) + ID_W'(1)) : id_q;

	always_comb begin
		for (int j = 0; j < MASK_W; j++) begin
			mask_bit[j] = ({{(32-IDX_W){1'b0}}, sel} == 32'(j));
		end
	end

	always_comb begin
		wr_en     = 1'b0;
		en_val    = 1'b0;
		wr_exp    = 1'b0;
		exp_val   = 1'b0;
		wr_el     = 1'b0;
		el_val    = '0;
		wr_per    = 1'b0;
		per_val   = '0;
		mask_set  = 1'b0;
		grant_set = 1'b0;
		ok_set    = 1'b0;
		case (act_q)
			ACT_TICK: begin
				if (cur_en && (cur_per != '0)) begin
					wr_el = 1'b1;
					if (hit) begin
						wr_exp   = 1'b1;
						exp_val  = 1'b1;
						mask_set = 1'b1;
					end else begin
						el_val = sat;
					end
				end
			end
			ACT_SET: begin
				if ((per_q != '0) && (id_ok || (alloc_mode && !cur_en))) begin
					wr_en     = 1'b1;
					en_val    = 1'b1;
					wr_per    = 1'b1;
					per_val   = per_q;
					wr_el     = 1'b1;
					grant_set = 1'b1;
				end
			end
			ACT_KILL: begin
				// A kill clears the timer even when it was not running.
				if (id_ok) begin
					wr_en  = 1'b1;
					wr_exp = 1'b1;
					wr_el  = 1'b1;
					wr_per = 1'b1;
					ok_set = cur_en;
				end
			end
			ACT_RESTART: begin
				if (id_ok && cur_en) begin
					wr_el  = 1'b1;
					ok_set = 1'b1;
				end
			end
			ACT_QUERY: begin
				if (id_ok && cur_en && cur_exp) begin
					wr_exp = 1'b1;
					ok_set = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Sweeps end at the last timer; an allocation also ends at the first free one.
	assign st.done     = !sweep || (idx_q == LAST_IDX) || (alloc_mode && !cur_en);
	assign st.out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= DEFAULT_TICK;
		end else if (cfg_valid) begin
			tick_q <= cfg_tick_ms;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= req_action;
			id_q  <= req_timer_id;
			per_q <= req_period_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			granted_q <= '0;
			ok_q      <= 1'b0;
			mask_q    <= '0;
		end else if (cmd.load) begin
			idx_q     <= '0;
			granted_q <= '0;
			ok_q      <= 1'b0;
			mask_q    <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + IDX_W'(1);
			if (grant_set) begin
				granted_q <= grant_val;
			end
			if (ok_set) begin
				ok_q <= 1'b1;
			end
			if (mask_set) begin
				mask_q <= mask_q | mask_bit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= '0;
			expired_q <= '0;
			for (int i = 0; i < TIMERS; i++) begin
				elapsed_q[i] <= '0;
				period_q[i]  <= '0;
			end
		end else if (cmd.step) begin
			if (wr_en) begin
				enabled_q[sel] <= en_val;
			end
			if (wr_exp) begin
				expired_q[sel] <= exp_val;
			end
			if (wr_el) begin
				elapsed_q[sel] <= el_val;
			end
			if (wr_per) begin
				period_q[sel] <= per_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_granted_q <= granted_q;
			out_ok_q      <= ok_q;
			out_mask_q    <= mask_q;
		end
	end

	assign rsp_valid        = out_valid_q;
	assign rsp_granted_id   = out_granted_q;
	assign rsp_success      = out_ok_q;
	assign rsp_expired_mask = out_mask_q;

	a_valid_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.push))
		else $error("output word appeared without a push");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (idx_q == '0 && granted_q == '0 && !ok_q && mask_q == '0))
		else $error("result accumulators not cleared on a new word");

	a_mask_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && act_q != ACT_TICK) |-> (mask_q == '0))
		else $error("expiry mask reported for a command");

	a_grant_set_only: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && act_q != ACT_SET) |-> (granted_q == '0))
		else $error("granted id reported for a non-set action");

endmodule

// ===== rtl/core/software_timer_bank.sv =====
// Channel  Dir  Words carried
// req      in   action, timer_id, period_ms
// rsp      out  granted_id, success, expired_mask (one per req word)
// cfg      in   tick_ms, always ready
//
// A tick visits every timer before its result is pushed: one shared
// add-and-compare unit visits one timer per cycle. Set with id zero visits
// timers until the first free one; other commands take a single step. The
// next req word is taken once the controller is back in idle after the push.
// Reset clears all timers and loads a tick size of ten; no clearing pass.
// A stalled rsp holds its word; the block waits only if a second result is due.
module software_timer_bank import stb_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	stb_req_if.sink req,
	stb_rsp_if.source rsp,
	stb_cfg_if.sink cfg
);

	stb_cmd_t    cmd;
	stb_status_t st;

	assign cfg.ready = 1'b1;

	stb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	stb_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.req_action       (req.action),
		.req_timer_id     (req.timer_id),
		.req_period_ms    (req.period_ms),
		.cfg_valid        (cfg.valid),
		.cfg_tick_ms      (cfg.tick_ms),
		.rsp_valid        (rsp.valid),
		.rsp_ready        (rsp.ready),
		.rsp_granted_id   (rsp.granted_id),
		.rsp_success      (rsp.success),
		.rsp_expired_mask (rsp.expired_mask)
	);

endmodule

// ===== verif/software_timer_bank_tb.sv =====
module software_timer_bank_tb;
	import stb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ACT_SPARE_LO = 5;
	localparam int ACT_SPARE_HI = 7;
	localparam int GAP_PCT      = 32;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [ID_W-1:0]    timer_id;
		logic [COUNT_W-1:0] period_ms;
	} timer_cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]   granted_id;
		logic              success;
		logic [MASK_W-1:0] expired_mask;
	} timer_reply_t;

	logic clk = 1'b0;
	logic arst_n;

	stb_req_if req();
	stb_rsp_if rsp();
	stb_cfg_if cfg();

	software_timer_bank dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	always #10 clk = ~clk;

	// Shadow copy of the timer bank.
	logic [TICK_W-1:0]  tick_size;
	logic               armed [TIMERS];
	logic [COUNT_W-1:0] count [TIMERS];
	logic [COUNT_W-1:0] limit [TIMERS];
	logic               fired [TIMERS];

	timer_cmd_t   cmd_backlog[$];
	timer_reply_t reply_due[$];
	timer_cmd_t   on_wire;
	int           errors = 0;
	int           req_gap_pct = GAP_PCT;
	int           rsp_gap_pct = GAP_PCT;

	function automatic logic id_in_bank(logic [ID_W-1:0] id);
		return id >= 1 && id <= TIMERS;
	endfunction

	function automatic timer_reply_t apply_timer_cmd(timer_cmd_t c);
		timer_reply_t r;
		logic [COUNT_W-1:0] step;
		logic [COUNT_W:0] sum;
		int k;
		r = '0;
		k = int'(c.timer_id) - 1;
		case (c.action)
			ACT_TICK: begin
				step = (tick_size == '0) ? COUNT_W'(DEFAULT_TICK) : COUNT_W'(tick_size);
				for (int i = 0; i < TIMERS; i++) begin
					if (armed[i] && limit[i] != '0) begin
						sum = {1'b0, count[i]} + {1'b0, step};
						count[i] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
						if (count[i] >= limit[i]) begin
							fired[i] = 1'b1;
							count[i] = '0;
							if (i < MASK_W)
								r.expired_mask[i] = 1'b1;
						end
					end
				end
			end
			ACT_SET: begin
				if (c.period_ms != '0) begin
					if (id_in_bank(c.timer_id)) begin
						armed[k] = 1'b1;
						limit[k] = c.period_ms;
						count[k] = '0;
						r.granted_id = c.timer_id;
					end else if (c.timer_id == '0) begin
						for (int i = 0; i < TIMERS; i++) begin
							if (!armed[i]) begin
								armed[i] = 1'b1;
								limit[i] = c.period_ms;
								count[i] = '0;
								r.granted_id = ID_W'(i + 1);
								break;
							end
						end
					end
				end
			end
			ACT_KILL: begin
				if (id_in_bank(c.timer_id)) begin
					limit[k] = '0;
					count[k] = '0;
					fired[k] = 1'b0;
					r.success = armed[k];
					armed[k] = 1'b0;
				end
			end
			ACT_RESTART: begin
				if (id_in_bank(c.timer_id) && armed[k]) begin
					count[k] = '0;
					r.success = 1'b1;
				end
			end
			ACT_QUERY: begin
				if (id_in_bank(c.timer_id) && armed[k] && fired[k]) begin
					fired[k] = 1'b0;
					r.success = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Driver: the next word goes on the wire once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.action <= ACT_TICK;
			req.timer_id <= '0;
			req.period_ms <= '0;
		end else begin
			if (req.valid && req.ready)
				reply_due.push_back(apply_timer_cmd(on_wire));
			if (!req.valid || req.ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
					on_wire = cmd_backlog.pop_front();
					req.valid <= 1'b1;
					req.action <= on_wire.action;
					req.timer_id <= on_wire.timer_id;
					req.period_ms <= on_wire.period_ms;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every result word is matched against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (reply_due.size() == 0) begin
					$display("%0t: unexpected word, actual %0d/%0d/%h", $time,
						rsp.granted_id, rsp.success, rsp.expired_mask);
					errors++;
				end else begin
					timer_reply_t e;
					e = reply_due.pop_front();
					if (rsp.granted_id !== e.granted_id) begin
						$display("%0t: granted_id expected %0d actual %0d", $time,
							e.granted_id, rsp.granted_id);
						errors++;
					end
					if (rsp.success !== e.success) begin
						$display("%0t: success expected %0d actual %0d", $time,
							e.success, rsp.success);
						errors++;
					end
					if (rsp.expired_mask !== e.expired_mask) begin
						$display("%0t: expired_mask expected %h actual %h", $time,
							e.expired_mask, rsp.expired_mask);
						errors++;
					end
				end
			end
			rsp.ready <= ($urandom_range(99) >= rsp_gap_pct);
		end
	end

	task automatic queue_cmd(logic [ACT_W-1:0] a, logic [ID_W-1:0] id,
			logic [COUNT_W-1:0] p);
		timer_cmd_t c;
		c.action = a;
		c.timer_id = id;
		c.period_ms = p;
		cmd_backlog.push_back(c);
	endtask

	function automatic logic [COUNT_W-1:0] pick_period();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(300, 1);
		if (r < 75)
			return $urandom_range(5000, 301);
		if (r < 90)
			return $urandom();
		return '0;
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 14)
			return ID_W'($urandom_range(31, TIMERS + 1));
		return ID_W'($urandom_range(TIMERS, 1));
	endfunction

	function automatic timer_cmd_t pick_cmd();
		timer_cmd_t c;
		int r;
		r = $urandom_range(99);
		c.timer_id = pick_id();
		c.period_ms = pick_period();
		if (r < 40) begin
			c.action = ACT_TICK;
		end else if (r < 60) begin
			c.action = ACT_SET;
			if ($urandom_range(1) == 0)
				c.timer_id = '0;
		end else if (r < 70) begin
			c.action = ACT_KILL;
		end else if (r < 80) begin
			c.action = ACT_RESTART;
		end else if (r < 95) begin
			c.action = ACT_QUERY;
		end else begin
			c.action = ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
		end
		return c;
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || req.valid || reply_due.size() != 0);
	endtask

	task automatic write_tick(logic [TICK_W-1:0] v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.tick_ms <= v;
		do
			@(posedge clk);
		while (!cfg.ready);
		tick_size = v;
		cfg.valid <= 1'b0;
	endtask

	initial begin
		logic [TICK_W-1:0] tick_plan[6];
		tick_plan = '{TICK_W'(0), TICK_W'(1), TICK_W'(1000), TICK_W'(1023),
			TICK_W'($urandom_range(999, 2)), TICK_W'(7)};
		cfg.valid = 1'b0;
		cfg.tick_ms = '0;
		tick_size = DEFAULT_TICK;
		for (int i = 0; i < TIMERS; i++) begin
			armed[i] = 1'b0;
			count[i] = '0;
			limit[i] = '0;
			fired[i] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		queue_cmd(ACT_SET, 0, 1);
		queue_cmd(ACT_TICK, 0, 0);
		queue_cmd(ACT_QUERY, 1, 0);
		queue_cmd(ACT_QUERY, 1, 0);
		queue_cmd(ACT_SET, ID_W'(TIMERS), '1);
		queue_cmd(ACT_SET, ID_W'(TIMERS + 1), 5);
		queue_cmd(ACT_SET, 31, 5);
		queue_cmd(ACT_SET, 3, 0);
		queue_cmd(ACT_SET, 0, 0);
		queue_cmd(ACT_RESTART, ID_W'(TIMERS), 0);
		queue_cmd(ACT_RESTART, 0, 0);
		queue_cmd(ACT_RESTART, 5, 0);
		queue_cmd(ACT_QUERY, 0, 0);
		queue_cmd(ACT_QUERY, 7, 0);
		queue_cmd(ACT_TICK, 31, '1);
		queue_cmd(ACT_KILL, 1, 0);
		queue_cmd(ACT_QUERY, 1, 0);
		queue_cmd(ACT_KILL, 1, 0);
		queue_cmd(ACT_KILL, 0, 0);
		queue_cmd(ACT_KILL, 31, 0);
		queue_cmd(ACT_W'(ACT_SPARE_LO), 31, '1);
		queue_cmd(ACT_W'(ACT_SPARE_LO + 1), 16, 32'h5555_AAAA);
		queue_cmd(ACT_W'(ACT_SPARE_HI), 1, 1);
		queue_cmd(ACT_SET, 0, 20);
		queue_cmd(ACT_TICK, 0, 0);
		wait_idle();

		foreach (tick_plan[ph]) begin
			write_tick(tick_plan[ph]);
			// One phase runs with both sides streaming at full rate.
			req_gap_pct = (ph == 2) ? 0 : GAP_PCT;
			rsp_gap_pct = (ph == 2) ? 0 : GAP_PCT;
			// Fill the whole bank so the next allocation finds no free timer.
			for (int i = 0; i <= TIMERS; i++)
				queue_cmd(ACT_SET, 0, $urandom_range(200, 1));
			repeat (140)
				cmd_backlog.push_back(pick_cmd());
			wait_idle();
		end

		repeat (TIMERS + 4) @(posedge clk);
		if (errors == 0 && reply_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
